// ===== design/lbs_pkg.sv =====
// Package for the LED blink sequencer: request codes, input kinds, status codes,
// program store sizing, and stream payload widths.
// No dependencies.
package lbs_pkg;

    localparam int PROG_DEPTH  = 32;
    localparam int PROG_IDX_W  = 5;
    localparam int POS_W       = 6;
    localparam int MAX_STEPS   = 33;
    localparam int STEP_W      = $clog2(MAX_STEPS + 1);

    localparam int S_TDATA_W   = 40;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 24;

    localparam logic [15:0] PERIOD_SLOW = 16'd250;
    localparam logic [15:0] PERIOD_FAST = 16'd100;
    localparam logic [6:0]  CHUNK_MS    = 7'd100;

    localparam logic [7:0] RQ_READ   = 8'hD0;
    localparam logic [7:0] RQ_TOGGLE = 8'hD1;
    localparam logic [7:0] RQ_SET    = 8'hD3;
    localparam logic [7:0] RQ_SEQ    = 8'hD4;
    localparam logic [7:0] RQ_BOOT   = 8'hB0;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_REQ    = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_IGNORE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_REPLY       = 2'd1,
        ST_UNSUPPORTED = 2'd2,
        ST_BOOT        = 2'd3
    } t_status;

endpackage

// ===== design/led_blink_sequencer.sv =====
// LED blink sequencer top level: request decode, blink delay timer and the
// program sequencer that steps one opcode fetch per cycle.
// Depends on lbs_pkg.
//
// Channel   Direction  Contents
// s_axis    in         tuser kind, tdata request/value/byte/index, tlast final byte
// m_axis    out        tdata led/status/reply/length/playing
//
// A control request, data byte or ignored kind is handled when it is accepted, and
// its result is registered. A tick passes through S_TICK, then through S_RUN once
// per program fetch through the shared fetch/decode step, and once more when the
// step bound is reached, then through S_DONE, which registers its result.
// The input is not ready while a tick is in work or a result is still held.
// Reset clears the 32-byte program store and all other state but the output data register.
module led_blink_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [7:0] request_code, [23:8] setup_value, [31:24] data_byte,
    // [36:32] data_index, [39:37] zero
    input  logic [lbs_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] kind
    input  logic [lbs_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    input  logic                           i_s_axis_tlast,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [0] led, [2:1] status, [18:3] reply_value, [20:19] reply_length,
    // [21] playing, [23:22] zero
    output logic [lbs_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);
    import lbs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_RUN,
        S_DONE
    } t_state;

    t_state                 r_state, n_state;
    logic [15:0]            r_period, n_period;
    logic                   r_seq, n_seq;
    logic [7:0]             r_store [PROG_DEPTH];
    logic [POS_W-1:0]       r_pos, n_pos;
    logic                   r_led, n_led;
    logic [15:0]            r_delay, n_delay;
    logic [6:0]             r_chunk, n_chunk;
    logic [15:0]            r_capt, n_capt;
    logic                   r_running, n_running;
    logic [STEP_W-1:0]      r_steps, n_steps;
    logic                   r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0]   r_out_data, n_out_data;

    logic                   wr_en;
    logic [PROG_IDX_W-1:0]  wr_addr;
    logic [7:0]             wr_data;

    logic                   accept;
    t_kind                  in_kind;
    logic [7:0]             in_code;
    logic [15:0]            in_value;
    logic [7:0]             in_byte;
    logic [PROG_IDX_W-1:0]  in_index;

    logic                   adv_start;
    logic [15:0]            adv_src;
    logic [15:0]            adv_cap;
    logic [6:0]             adv_chunk_in;
    logic [15:0]            adv_rem;
    logic [6:0]             adv_chunk;
    logic                   adv_end;
    logic [7:0]             op;

    function automatic logic [M_TDATA_W-1:0] pack_out(
        input logic        led,
        input t_status     status,
        input logic [15:0] reply,
        input logic [1:0]  rlen,
        input logic        playing
    );
        logic [M_TDATA_W-1:0] word;
        word        = '0;
        word[0]     = led;
        word[2:1]   = status;
        word[18:3]  = reply;
        word[20:19] = rlen;
        word[21]    = playing;
        return word;
    endfunction

    assign in_kind  = t_kind'(i_s_axis_tuser[1:0]);
    assign in_code  = i_s_axis_tdata[7:0];
    assign in_value = i_s_axis_tdata[23:8];
    assign in_byte  = i_s_axis_tdata[31:24];
    assign in_index = i_s_axis_tdata[36:32];

    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign op = r_store[r_pos[PROG_IDX_W-1:0]];

    // One millisecond of the blink delay, starting a new one from the period if none runs.
    always_comb begin
        adv_start    = !r_running && (r_delay == 16'd0);
        adv_src      = adv_start ? r_period : r_delay;
        adv_cap      = adv_start ? r_period : r_capt;
        adv_chunk_in = adv_start ? 7'd0 : r_chunk;
        adv_rem      = adv_src - 16'd1;
        adv_chunk    = adv_chunk_in + 7'd1;
        if (adv_chunk >= CHUNK_MS) begin
            adv_chunk = 7'd0;
            if (adv_rem != 16'd0 && r_period != adv_cap) begin
                adv_rem = 16'd0;
            end
        end
        adv_end = (adv_rem == 16'd0);
        if (adv_end) begin
            adv_chunk = 7'd0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_period    = r_period;
        n_seq       = r_seq;
        n_pos       = r_pos;
        n_led       = r_led;
        n_delay     = r_delay;
        n_chunk     = r_chunk;
        n_capt      = r_capt;
        n_running   = r_running;
        n_steps     = r_steps;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        wr_en       = 1'b0;
        wr_addr     = in_index;
        wr_data     = in_byte;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    n_out_data  = pack_out(r_led, ST_OK, 16'd0, 2'd0, r_running);
                    case (in_kind)
                        KIND_TICK: begin
                            n_out_valid = 1'b0;
                            n_state     = S_TICK;
                        end
                        KIND_REQ: begin
                            case (in_code)
                                RQ_READ: begin
                                    n_out_data = pack_out(r_led, ST_REPLY, r_period, 2'd2,
                                                          r_running);
                                end
                                RQ_TOGGLE: begin
                                    n_period = (r_period == PERIOD_SLOW) ? PERIOD_FAST
                                                                         : PERIOD_SLOW;
                                    n_seq    = 1'b0;
                                end
                                RQ_SET: begin
                                    n_period = in_value;
                                    n_seq    = 1'b0;
                                end
                                RQ_SEQ: begin
                                    n_seq = 1'b0;
                                end
                                RQ_BOOT: begin
                                    n_out_data = pack_out(r_led, ST_BOOT, 16'd0, 2'd0,
                                                          r_running);
                                end
                                default: begin
                                    n_out_data = pack_out(r_led, ST_UNSUPPORTED, 16'd0, 2'd0,
                                                          r_running);
                                end
                            endcase
                        end
                        KIND_DATA: begin
                            if (in_code == RQ_SEQ) begin
                                wr_en = ({1'b0, in_index} < POS_W'(PROG_DEPTH));
                                if (i_s_axis_tlast) begin
                                    n_seq    = 1'b1;
                                    n_period = 16'd0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_TICK: begin
                n_steps = '0;
                n_state = S_DONE;
                if (r_running) begin
                    if (r_delay != 16'd0) begin
                        n_delay = adv_rem;
                        n_chunk = adv_chunk;
                        if (adv_end) begin
                            n_state = S_RUN;
                        end
                    end else begin
                        n_state = S_RUN;
                    end
                end else if (r_delay == 16'd0 && r_seq) begin
                    n_running = 1'b1;
                    n_period  = PERIOD_FAST;
                    n_pos     = '0;
                    n_delay   = 16'd0;
                    n_chunk   = 7'd0;
                    n_state   = S_RUN;
                end else if (r_delay == 16'd0 && r_period == 16'd0) begin
                    n_led = !r_led;
                end else begin
                    n_capt  = adv_cap;
                    n_delay = adv_rem;
                    n_chunk = adv_chunk;
                    if (adv_end) begin
                        n_led = !r_led;
                        if (r_seq) begin
                            n_running = 1'b1;
                            n_period  = PERIOD_FAST;
                            n_pos     = '0;
                            n_state   = S_RUN;
                        end
                    end
                end
            end

            S_RUN: begin
                if (r_steps == STEP_W'(MAX_STEPS)) begin
                    n_state = S_DONE;
                end else if (r_pos >= POS_W'(PROG_DEPTH) || op == 8'd0 || !r_seq) begin
                    n_pos     = r_pos + POS_W'(1);
                    n_led     = 1'b0;
                    n_seq     = 1'b0;
                    n_running = 1'b0;
                    n_delay   = 16'd0;
                    n_chunk   = 7'd0;
                    n_state   = S_DONE;
                    if (r_pos >= POS_W'(PROG_DEPTH)) begin
                        n_pos = r_pos;
                    end
                end else if (op[7]) begin
                    n_pos   = POS_W'(op[4:0]);
                    n_steps = r_steps + STEP_W'(1);
                end else begin
                    n_pos   = r_pos + POS_W'(1);
                    n_led   = op[4];
                    n_capt  = r_period;
                    n_delay = {6'd0, op[3:0], 6'd0};
                    n_chunk = 7'd0;
                    n_steps = r_steps + STEP_W'(1);
                    if (op[3:0] != 4'd0) begin
                        n_state = S_DONE;
                    end
                end
            end

            S_DONE: begin
                n_out_valid = 1'b1;
                n_out_data  = pack_out(r_led, ST_OK, 16'd0, 2'd0, r_running);
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= PERIOD_SLOW;
            r_seq       <= 1'b0;
            r_pos       <= '0;
            r_led       <= 1'b0;
            r_delay     <= 16'd0;
            r_chunk     <= 7'd0;
            r_capt      <= PERIOD_SLOW;
            r_running   <= 1'b0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < PROG_DEPTH; i++) begin
                r_store[i] <= 8'd0;
            end
        end else begin
            r_state     <= n_state;
            r_period    <= n_period;
            r_seq       <= n_seq;
            r_pos       <= n_pos;
            r_led       <= n_led;
            r_delay     <= n_delay;
            r_chunk     <= n_chunk;
            r_capt      <= n_capt;
            r_running   <= n_running;
            r_steps     <= n_steps;
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                r_store[wr_addr] <= wr_data;
            end
        end
        r_out_data <= n_out_data;
    end

`ifndef SYNTHESIS
    a_steps_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= STEP_W'(MAX_STEPS))
        else $error("Opcode step count exceeded its bound.");

    a_chunk_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chunk < CHUNK_MS)
        else $error("Chunk counter reached the chunk length.");

    a_run_needs_playback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> r_running)
        else $error("Program sequencer stepped without playback running.");

    a_tick_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK || r_state == S_RUN) |-> !r_out_valid)
        else $error("A result was pending while a tick was in work.");
`endif

endmodule

// ===== sim/tb_led_blink_sequencer.sv =====
`timescale 1ns / 1ps
// Testbench for led_blink_sequencer: a queue-fed stream driver, a result monitor
// and a cycle-free predictor of the blink timer and program sequencer.
// Depends on lbs_pkg and the led_blink_sequencer RTL.
module tb_led_blink_sequencer;
    import lbs_pkg::*;

    typedef struct packed {
        logic        last;
        t_kind       kind;
        logic [4:0]  index;
        logic [7:0]  data;
        logic [15:0] value;
        logic [7:0]  code;
    } t_lbs_req;

    typedef struct packed {
        logic        playing;
        logic [1:0]  rlen;
        logic [15:0] reply;
        t_status     status;
        logic        led;
    } t_lbs_result;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    t_lbs_req    pending_reqs[$];
    t_lbs_result exp_results[$];
    t_lbs_req    cur_req;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          n_planned = 0;
    int          n_results = 0;
    int          n_errors = 0;

    logic [15:0] pr_period, pr_snap_period, pr_wait_ms;
    logic [6:0]  pr_chunk_ms;
    logic [POS_W-1:0] pr_pc;
    logic        pr_armed, pr_playing, pr_led;
    logic [7:0]  pr_prog [PROG_DEPTH];

    led_blink_sequencer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void pr_arm_wait(logic [15:0] ms);
        pr_snap_period = pr_period;
        pr_wait_ms = ms;
        pr_chunk_ms = '0;
    endfunction

    // Long waits are checked at every 100 ms boundary and end early when the
    // period has changed since the wait began.
    function automatic bit pr_wait_step();
        pr_wait_ms = pr_wait_ms - 16'd1;
        pr_chunk_ms = pr_chunk_ms + 7'd1;
        if (pr_chunk_ms >= CHUNK_MS) begin
            pr_chunk_ms = '0;
            if (pr_wait_ms != 0 && pr_period != pr_snap_period) begin
                pr_wait_ms = '0;
            end
        end
        if (pr_wait_ms == 0) begin
            pr_chunk_ms = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void pr_halt();
        pr_led = 1'b0;
        pr_armed = 1'b0;
        pr_playing = 1'b0;
        pr_wait_ms = '0;
        pr_chunk_ms = '0;
    endfunction

    function automatic void pr_fetch_ops();
        logic [7:0] op;
        for (int s = 0; s < MAX_STEPS; s++) begin
            if (pr_pc >= PROG_DEPTH) begin
                pr_halt();
                return;
            end
            op = pr_prog[pr_pc[PROG_IDX_W-1:0]];
            pr_pc = pr_pc + 1'b1;
            if (op == 8'h00 || !pr_armed) begin
                pr_halt();
                return;
            end
            if (op[7]) begin
                pr_pc = {1'b0, op[4:0]};
                continue;
            end
            pr_led = op[4];
            pr_arm_wait({6'd0, op[3:0], 6'd0});
            if (op[3:0] != 4'd0) begin
                return;
            end
        end
    endfunction

    function automatic void pr_launch();
        pr_playing = 1'b1;
        pr_period = PERIOD_FAST;
        pr_pc = '0;
        pr_wait_ms = '0;
        pr_chunk_ms = '0;
        pr_fetch_ops();
    endfunction

    function automatic void pr_tick();
        if (pr_playing) begin
            if (pr_wait_ms != 0) begin
                if (!pr_wait_step()) begin
                    return;
                end
            end
            pr_fetch_ops();
            return;
        end
        if (pr_wait_ms == 0) begin
            if (pr_armed) begin
                pr_launch();
                return;
            end
            if (pr_period == 0) begin
                pr_led = ~pr_led;
                return;
            end
            pr_arm_wait(pr_period);
        end
        if (pr_wait_step()) begin
            pr_led = ~pr_led;
            if (pr_armed) begin
                pr_launch();
            end
        end
    endfunction

    function automatic t_lbs_result predict_result(t_lbs_req r);
        t_lbs_result res;
        res = '0;
        case (r.kind)
            KIND_TICK: pr_tick();
            KIND_REQ: begin
                case (r.code)
                    RQ_READ: begin
                        res.status = ST_REPLY;
                        res.reply = pr_period;
                        res.rlen = 2'd2;
                    end
                    RQ_TOGGLE: begin
                        pr_period = (pr_period == PERIOD_SLOW) ? PERIOD_FAST : PERIOD_SLOW;
                        pr_armed = 1'b0;
                    end
                    RQ_SET: begin
                        pr_period = r.value;
                        pr_armed = 1'b0;
                    end
                    RQ_SEQ: pr_armed = 1'b0;
                    RQ_BOOT: res.status = ST_BOOT;
                    default: res.status = ST_UNSUPPORTED;
                endcase
            end
            KIND_DATA: begin
                if (r.code == RQ_SEQ) begin
                    if (r.index < PROG_DEPTH) begin
                        pr_prog[r.index] = r.data;
                    end
                    if (r.last) begin
                        pr_armed = 1'b1;
                        pr_period = '0;
                    end
                end
            end
            default: ;
        endcase
        res.led = pr_led;
        res.playing = pr_playing;
        return res;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            pr_period = PERIOD_SLOW;
            pr_snap_period = PERIOD_SLOW;
            pr_wait_ms = '0;
            pr_chunk_ms = '0;
            pr_pc = '0;
            pr_armed = 1'b0;
            pr_playing = 1'b0;
            pr_led = 1'b0;
            for (int k = 0; k < PROG_DEPTH; k++) begin
                pr_prog[k] = 8'h00;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                exp_results.push_back(predict_result(cur_req));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = pending_reqs.pop_front();
                    s_tdata <= {3'b000, cur_req.index, cur_req.data, cur_req.value,
                                cur_req.code};
                    s_tuser <= cur_req.kind;
                    s_tlast <= cur_req.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        if (n_errors <= 100) begin
            $display("[%0t] result %0d: %s is %0h, expected %0h", $time, n_results, what,
                     got, want);
        end
    endtask

    always @(posedge clk) begin
        t_lbs_result got, want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[21:0];
                if (exp_results.size() == 0) begin
                    report_mismatch("result with no request pending", int'(m_tdata), 0);
                end else begin
                    want = exp_results.pop_front();
                    if (got.led !== want.led) begin
                        report_mismatch("led", int'(got.led), int'(want.led));
                    end
                    if (got.status !== want.status) begin
                        report_mismatch("status", int'(got.status), int'(want.status));
                    end
                    if (got.reply !== want.reply) begin
                        report_mismatch("reply_value", int'(got.reply), int'(want.reply));
                    end
                    if (got.rlen !== want.rlen) begin
                        report_mismatch("reply_length", int'(got.rlen), int'(want.rlen));
                    end
                    if (got.playing !== want.playing) begin
                        report_mismatch("playing", int'(got.playing), int'(want.playing));
                    end
                end
                n_results++;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_lbs_req any_item(t_kind k);
        t_lbs_req r;
        r.code = 8'($urandom);
        r.value = 16'($urandom);
        r.data = 8'($urandom);
        r.index = 5'($urandom);
        r.last = 1'($urandom);
        r.kind = k;
        return r;
    endfunction

    task automatic push_item(t_lbs_req r);
        pending_reqs.push_back(r);
        if (!(r.kind == KIND_IGNORE || (r.kind == KIND_DATA && r.code != RQ_SEQ))) begin
            n_planned++;
        end
    endtask

    task automatic add_ticks(int n);
        repeat (n) push_item(any_item(KIND_TICK));
    endtask

    task automatic add_request(logic [7:0] code, logic [15:0] value);
        t_lbs_req r;
        r = any_item(KIND_REQ);
        r.code = code;
        r.value = value;
        push_item(r);
    endtask

    task automatic add_byte(logic [7:0] code, logic [4:0] index, logic [7:0] data, bit last);
        t_lbs_req r;
        r = any_item(KIND_DATA);
        r.code = code;
        r.index = index;
        r.data = data;
        r.last = last;
        push_item(r);
    endtask

    // Programs favor zero-time opcodes and jumps so that playback stays short.
    task automatic add_program(int len, bit long_ok);
        logic [7:0] op;
        int sel;
        for (int i = 0; i < len; i++) begin
            sel = $urandom_range(99);
            op = 8'($urandom);
            if (sel < 8) begin
                op = 8'h00;
            end else if (sel < 35) begin
                op[7] = 1'b1;
                op[4:0] = 5'($urandom_range(len - 1));
            end else if (sel < 80) begin
                op[7] = 1'b0;
                op[3:0] = 4'd0;
            end else if (long_ok && sel < 90) begin
                op[7] = 1'b0;
                op[3:0] = 4'($urandom_range(15, 2));
            end else begin
                op[7] = 1'b0;
                op[3:0] = 4'd1;
            end
            add_byte(RQ_SEQ, 5'(i), op, i == len - 1);
        end
    endtask

    initial begin
        logic [7:0] ctl_codes [4];
        logic [7:0] noise_codes [6];
        t_lbs_req r;
        int sel;
        int phase_end;
        bit long_ok;
        ctl_codes = '{RQ_TOGGLE, RQ_SET, RQ_SEQ, RQ_READ};
        noise_codes = '{RQ_READ, RQ_BOOT, RQ_TOGGLE, RQ_SEQ, RQ_SET, 8'hD2};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        add_request(RQ_READ, 16'h0000);
        add_request(RQ_TOGGLE, 16'h0000);
        add_request(RQ_READ, 16'hFFFF);
        add_request(RQ_SET, 16'hFFFF);
        add_request(RQ_TOGGLE, 16'h0000);
        add_request(RQ_READ, 16'h0000);
        add_request(RQ_SET, 16'h0000);
        add_ticks(2);
        add_request(RQ_SET, 16'h0001);
        add_ticks(2);
        add_request(RQ_BOOT, 16'hFFFF);
        add_request(8'h00, 16'h0000);
        add_request(8'hFF, 16'hFFFF);
        push_item(any_item(KIND_IGNORE));
        add_byte(RQ_SET, 5'd0, 8'hFF, 1'b1);
        add_byte(RQ_SEQ, 5'd0, 8'h10, 1'b0);
        add_byte(RQ_SEQ, 5'd1, 8'h81, 1'b1);
        add_ticks(3);
        add_request(RQ_SEQ, 16'h0000);
        add_ticks(1);
        add_request(RQ_READ, 16'h0000);

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = (p == 1) ? 64 : (p == 3) ? 22 : 0;
            recv_stall_pct = (p == 2) ? 64 : (p == 3) ? 22 : 0;
            phase_end = 25 + (p + 1) * 232;
            while (n_planned < phase_end) begin
                sel = $urandom_range(99);
                if (sel < 45) begin
                    long_ok = ($urandom_range(7) == 0);
                    add_program(($urandom_range(9) == 0) ? 32 : $urandom_range(1, 8), long_ok);
                    add_ticks(long_ok ? $urandom_range(100, 220) : $urandom_range(1, 70));
                    if ($urandom_range(2) == 0) begin
                        add_request(ctl_codes[$urandom_range(3)], 16'($urandom_range(300)));
                        add_ticks(long_ok ? $urandom_range(100, 120) : $urandom_range(1, 30));
                    end
                end else if (sel < 65) begin
                    add_request(RQ_SET, 16'($urandom_range(4)));
                    add_ticks($urandom_range(1, 16));
                end else if (sel < 70) begin
                    add_request(RQ_SET, 16'($urandom_range(101, 220)));
                    add_ticks($urandom_range(90, 110));
                    if ($urandom_range(1) == 0) begin
                        add_request(RQ_TOGGLE, 16'h0000);
                    end else begin
                        add_request(RQ_SET, 16'($urandom_range(300)));
                    end
                    add_ticks($urandom_range(1, 110));
                end else if (sel < 85) begin
                    add_program($urandom_range(3, 6), 1'b0);
                    add_ticks($urandom_range(1, 5));
                    add_program($urandom_range(1, 4), 1'b0);
                    add_ticks($urandom_range(1, 40));
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        case ($urandom_range(4))
                            0: add_request(8'($urandom), 16'($urandom));
                            1: add_request(noise_codes[$urandom_range(5)], 16'($urandom));
                            2: push_item(any_item(KIND_IGNORE));
                            3: push_item(any_item(KIND_DATA));
                            default: begin
                                r = any_item(KIND_DATA);
                                r.code = RQ_SEQ;
                                push_item(r);
                            end
                        endcase
                    end
                end
            end
            while (pending_reqs.size() != 0 || s_tvalid || exp_results.size() != 0) begin
                @(posedge clk);
            end
        end

        repeat (40) @(posedge clk);
        if (n_errors == 0 && exp_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lbs_pkg.sv
design/led_blink_sequencer.sv
sim/tb_led_blink_sequencer.sv
